### design/x86_64_instruction_length_decoder_macros.svh
// assertion macros for the instruction length decoder
// used by the top level only
`ifndef X86_64_INSTRUCTION_LENGTH_DECODER_MACROS_SVH
`define X86_64_INSTRUCTION_LENGTH_DECODER_MACROS_SVH

// assert a property under active-high disable
`define XLD_ASSERT(label, dis, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (dis) prop) else $error(msg);

// assert an implication under active-high disable
`define XLD_IMPLIES(label, dis, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (dis) (ante) |-> (cons)) else $error(msg);

`endif

### design/xld_pkg.sv
// shared types and constants for the instruction length decoder
// no dependencies
package xld_pkg;

    localparam int WindowBytes = 16;

    typedef logic [7:0] t_byte;
    typedef logic [4:0] t_pos;

    typedef struct packed {
        logic osz;
        logic asz;
        logic rexw;
        t_pos p;
    } t_pfx;

    // opcode stage result
    typedef struct packed {
        logic    asz;
        logic    do_rm;
        t_pos    p;
        logic [3:0] offset;
        logic    ovf;
    } t_opc;

    function automatic logic is_legacy(input t_byte b);
        case (b)
            8'hF0, 8'hF2, 8'hF3, 8'h2E, 8'h36, 8'h3E,
            8'h26, 8'h64, 8'h65, 8'h66, 8'h67: is_legacy = 1'b1;
            default: is_legacy = 1'b0;
        endcase
    endfunction

    function automatic logic one_rm(input t_byte b);
        case (b)
            8'h62, 8'h63, 8'h69, 8'h6B, 8'hC0, 8'hC1, 8'hC4, 8'hC5, 8'hC6,
            8'hC7, 8'hD0, 8'hD1, 8'hD2, 8'hD3, 8'hF6, 8'hF7, 8'hFE,
            8'hFF: one_rm = 1'b1;
            default: one_rm = 1'b0;
        endcase
    endfunction

    function automatic logic one_i8(input t_byte b);
        case (b)
            8'h6A, 8'h6B, 8'h80, 8'h82, 8'h83, 8'hA8, 8'hC0, 8'hC1, 8'hC6,
            8'hCD, 8'hD4, 8'hD5, 8'hEB: one_i8 = 1'b1;
            default: one_i8 = 1'b0;
        endcase
    endfunction

    function automatic logic one_i32(input t_byte b);
        case (b)
            8'h68, 8'h69, 8'h81, 8'hA9, 8'hC7, 8'hE8, 8'hE9: one_i32 = 1'b1;
            default: one_i32 = 1'b0;
        endcase
    endfunction

    function automatic logic two_rm(input t_byte b);
        case (b)
            8'h0D, 8'hA3, 8'hA4, 8'hA5, 8'hAB, 8'hAC, 8'hAD, 8'hAE,
            8'hAF: two_rm = 1'b1;
            default: two_rm = 1'b0;
        endcase
    endfunction

endpackage

### design/xld_if.sv
// valid/ready channel interfaces for the instruction length decoder
// depends on nothing
interface xld_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] code_bytes_low;
    logic [63:0] code_bytes_high;
    modport source (output valid, code_bytes_low, code_bytes_high, input ready);
    modport sink (input valid, code_bytes_low, code_bytes_high, output ready);
endinterface

interface xld_out_if;
    logic       valid;
    logic       ready;
    logic [4:0] instr_length;
    logic       window_overflow;
    modport source (output valid, instr_length, window_overflow, input ready);
    modport sink (input valid, instr_length, window_overflow, output ready);
endinterface

### design/xld_prefix.sv
// prefix and rex scan over the window
// depends on xld_pkg
module xld_prefix #(
    parameter int MAX_LEGACY_PREFIXES = 14
) (
    input  logic [127:0]  i_win,
    output xld_pkg::t_pfx o_pfx
);
    import xld_pkg::*;

    logic [15:0] cont;
    t_byte       b;

    // continue flag for each position; first non-continuing position ends scan
    always_comb begin
        for (int k = 0; k < WindowBytes; k++) begin
            b = i_win[8*k +: 8];
            cont[k] = (k < MAX_LEGACY_PREFIXES && is_legacy(b)) || (b[7:4] == 4'h4);
        end
    end

    always_comb begin
        logic stop;
        stop = 1'b0;
        o_pfx = '0;
        for (int k = 0; k < WindowBytes; k++) begin
            if (!stop) begin
                if (cont[k]) begin
                    if (i_win[8*k +: 8] == 8'h66) o_pfx.osz = 1'b1;
                    else if (i_win[8*k +: 8] == 8'h67) o_pfx.asz = 1'b1;
                    else if (i_win[8*k+7 -: 5] == 5'b01001) o_pfx.rexw = 1'b1;
                    o_pfx.p = t_pos'(k + 1);
                end else begin
                    stop = 1'b1;
                end
            end
        end
    end
endmodule

### design/xld_opcode.sv
// opcode classification, immediate size and modrm decision
// depends on xld_pkg
module xld_opcode (
    input  logic [127:0]  i_win,
    input  xld_pkg::t_pfx i_pfx,
    output xld_pkg::t_opc o_opc
);
    import xld_pkg::*;

    function automatic t_byte rdb(input logic [127:0] w, input t_pos k);
        rdb = k[4] ? 8'h00 : w[8*k[3:0] +: 8];
    endfunction

    always_comb begin
        t_byte b, nb;
        logic [3:0] r, c;
        t_pos p;
        logic [3:0] off;
        logic ovf, rm;
        p = i_pfx.p;
        ovf = p[4];
        b = rdb(i_win, p);
        nb = '0;
        r = '0;
        c = '0;
        off = '0;
        rm = 1'b0;
        if (b == 8'h0F) begin
            p = p + 5'd1;
            ovf = ovf | p[4];
            b = rdb(i_win, p);
            if (b == 8'h38 || b == 8'h3A) begin
                if (b == 8'h3A) off = 4'd1;
                p = p + 5'd1;
                ovf = ovf | p[4];
                rm = 1'b1;
            end else begin
                r = b[7:4];
                c = b[3:0];
                if (r == 4'h8) off = 4'd4;
                else if ((r == 4'h7 && c < 4'd4) || b == 8'hA4 || b == 8'hC2 ||
                         (b > 8'hC3 && b <= 8'hC6) || b == 8'hBA || b == 8'hAC)
                    off = 4'd1;
                rm = two_rm(b) || (r != 4'h3 && r > 4'h0 && r < 4'h7) || b >= 8'hD0 ||
                     (r == 4'h7 && c != 4'h7) || r == 4'h9 || r == 4'hB ||
                     (r == 4'hC && c < 4'd8) || (r == 4'h0 && c < 4'd4);
            end
        end else begin
            r = b[7:4];
            c = b[3:0];
            nb = rdb(i_win, p + 5'd1);
            if ((b == 8'hF6 || b == 8'hF7) && (p == 5'd15)) ovf = 1'b1;
            if ((r == 4'hE && c < 4'd8) || (r == 4'hB && c < 4'd8) || r == 4'h7 ||
                (r < 4'h4 && (c == 4'h4 || c == 4'hC)) ||
                (b == 8'hF6 && nb[5:4] == 2'b00) || one_i8(b))
                off = 4'd1;
            else if (b == 8'hC2 || b == 8'hCA) off = 4'd2;
            else if (b == 8'hC8) off = 4'd3;
            else if ((r < 4'h4 && (c == 4'h5 || c == 4'hD)) || (r == 4'hB && c >= 4'd8) ||
                     (b == 8'hF7 && nb[5:4] == 2'b00) || one_i32(b)) begin
                if (b >= 8'hB8 && b <= 8'hBF) off = i_pfx.rexw ? 4'd8 : 4'd4;
                else if (b == 8'hC7 || b == 8'h69) off = 4'd4;
                else off = i_pfx.osz ? 4'd2 : 4'd4;
            end else if (r == 4'hA && c < 4'd4)
                off = i_pfx.rexw ? 4'd8 : (i_pfx.asz ? 4'd2 : 4'd4);
            else if (b == 8'hEA || b == 8'h9A)
                off = i_pfx.osz ? 4'd4 : 4'd6;
            rm = one_rm(b) || (r < 4'h4 && (c < 4'd4 || (c >= 4'd8 && c < 4'hC))) ||
                 r == 4'h8 || (r == 4'hD && c >= 4'd8);
        end
        o_opc.asz = i_pfx.asz;
        o_opc.do_rm = rm;
        o_opc.p = p;
        o_opc.offset = off;
        o_opc.ovf = ovf;
    end
endmodule

### design/xld_modrm.sv
// modrm, sib and displacement walk plus final length
// depends on xld_pkg
module xld_modrm (
    input  logic [127:0]  i_win,
    input  xld_pkg::t_opc i_opc,
    output logic [4:0]    o_len,
    output logic          o_ovf
);
    import xld_pkg::*;

    always_comb begin
        logic [5:0] p, s, len;
        t_byte m, sb;
        logic ovf, sib;
        p = {1'b0, i_opc.p};
        ovf = i_opc.ovf;
        s = '0;
        m = '0;
        sb = '0;
        sib = 1'b0;
        if (i_opc.do_rm) begin
            p = p + 6'd1;
            m = (p >= 6'd16) ? 8'h00 : i_win[8*p[3:0] +: 8];
            ovf = ovf | (p >= 6'd16);
            if (!i_opc.asz || m >= 8'h40) begin
                if (m < 8'hC0 && m[2:0] == 3'd4 && !i_opc.asz) begin
                    sib = 1'b1;
                    p = p + 6'd1;
                end
                s = p;
                if (m >= 8'h40 && m <= 8'h7F) p = p + 6'd1;
                else if ((m <= 8'h3F && m[2:0] == 3'd5) || (m >= 8'h80 && m <= 8'hBF))
                    p = p + (i_opc.asz ? 6'd2 : 6'd4);
                else if (sib) begin
                    sb = (s >= 6'd16) ? 8'h00 : i_win[8*s[3:0] +: 8];
                    ovf = ovf | (s >= 6'd16);
                    if (sb[2:0] == 3'd5) p = p + (m[6] ? 6'd1 : 6'd4);
                end
            end else if (m == 8'h26) begin
                p = p + 6'd2;
            end
        end
        len = p + 6'd1 + {2'b00, i_opc.offset};
        if (len > 6'd16) begin
            o_len = 5'd16;
            o_ovf = 1'b1;
        end else begin
            o_len = len[4:0];
            o_ovf = ovf;
        end
    end
endmodule

### design/x86_64_instruction_length_decoder.sv
// x86-64 instruction length decoder, three register stages
// throughput: one beat per cycle; stages advance together when the output is free
// reset: synchronous active-low i_rst_n clears all stage valid bits
// stages: prefix scan, opcode decode, modrm walk into output register
module x86_64_instruction_length_decoder #(
    parameter int MAX_LEGACY_PREFIXES = 14
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    xld_in_if.sink     i_in,
    xld_out_if.source  o_out
);
    import xld_pkg::*;

`include "x86_64_instruction_length_decoder_macros.svh"

    // pipeline moves when the output register is empty or being drained
    logic adv;

    logic         r_v1, r_v2, r_v3;
    logic [127:0] r_w1, r_w2;
    t_pfx         r_pfx;
    t_opc         r_opc;
    logic [4:0]   r_len;
    logic         r_ovf;

    t_pfx         n_pfx;
    t_opc         n_opc;
    logic [4:0]   n_len;
    logic         n_ovf;

    assign adv = !r_v3 || o_out.ready;
    assign i_in.ready = adv;

    // stage 1: prefix scan on the incoming window
    xld_prefix #(.MAX_LEGACY_PREFIXES(MAX_LEGACY_PREFIXES)) u_pfx (
        .i_win ({i_in.code_bytes_high, i_in.code_bytes_low}),
        .o_pfx (n_pfx)
    );

    // stage 2: opcode and immediate
    xld_opcode u_opc (
        .i_win (r_w1),
        .i_pfx (r_pfx),
        .o_opc (n_opc)
    );

    // stage 3: modrm walk and length saturation
    xld_modrm u_rm (
        .i_win (r_w2),
        .i_opc (r_opc),
        .o_len (n_len),
        .o_ovf (n_ovf)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (adv) begin
            r_v1 <= i_in.valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_w1  <= {i_in.code_bytes_high, i_in.code_bytes_low};
            r_pfx <= n_pfx;
            r_w2  <= r_w1;
            r_opc <= n_opc;
            r_len <= n_len;
            r_ovf <= n_ovf;
        end
    end

    assign o_out.valid           = r_v3;
    assign o_out.instr_length    = r_len;
    assign o_out.window_overflow = r_ovf;

    `XLD_IMPLIES(a_len_range, !i_rst_n, r_v3, r_len >= 5'd1 && r_len <= 5'd16, "length out of range")
    `XLD_IMPLIES(a_stall_hold, !i_rst_n, r_v3 && !o_out.ready, ##1 (r_v3 && $stable(r_len)), "stalled result changed")
    `XLD_IMPLIES(a_flow, !i_rst_n, adv && r_v2, ##1 r_v3, "beat lost in pipeline")
endmodule

### sim/tb_x86_64_instruction_length_decoder.sv
// self-checking testbench for the x86-64 instruction length decoder
// depends on xld_pkg and the xld_in_if / xld_out_if interfaces
module tb_x86_64_instruction_length_decoder;
    timeunit 1ns;
    timeprecision 1ps;

    import xld_pkg::*;

    localparam int PrefixLimit = 14;
    localparam int IdleLimit = 2000;
    localparam int RandomItems = 1500;

    typedef struct packed {
        logic [4:0] len;
        logic       ovf;
    } t_len_result;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    xld_in_if in_ch ();
    xld_out_if out_ch ();

    x86_64_instruction_length_decoder #(.MAX_LEGACY_PREFIXES(PrefixLimit)) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // windows waiting to be driven, and the lengths we still expect back
    logic [127:0]  window_queue[$];
    t_len_result   length_queue[$];
    int            error_count = 0;
    int            result_count = 0;
    int            overflow_count = 0;
    bit            quiet_phase = 1'b0;
    bit            hold_sender = 1'b0;
    int            src_idle = 0;
    int            snk_idle = 0;
    int            idle_cycles = 0;

    // --------------------------------------------------------------------
    // length predictor: prefix scan, opcode tables, modrm/sib/disp walk
    // --------------------------------------------------------------------
    function automatic logic [7:0] win_byte(input logic [127:0] w, input int k,
                                            inout bit past);
        if (k >= 16) begin
            past = 1'b1;
            return 8'h00;
        end
        return w[8*k +: 8];
    endfunction

    function automatic bit in_list(input logic [7:0] b, input int which);
        case (which)
            0: return b inside {8'hF0, 8'hF2, 8'hF3, 8'h2E, 8'h36, 8'h3E, 8'h26, 8'h64,
                                8'h65, 8'h66, 8'h67};
            1: return b inside {8'h62, 8'h63, 8'h69, 8'h6B, 8'hC0, 8'hC1, 8'hC4, 8'hC5,
                                8'hC6, 8'hC7, 8'hD0, 8'hD1, 8'hD2, 8'hD3, 8'hF6, 8'hF7,
                                8'hFE, 8'hFF};
            2: return b inside {8'h6A, 8'h6B, 8'h80, 8'h82, 8'h83, 8'hA8, 8'hC0, 8'hC1,
                                8'hC6, 8'hCD, 8'hD4, 8'hD5, 8'hEB};
            3: return b inside {8'h68, 8'h69, 8'h81, 8'hA9, 8'hC7, 8'hE8, 8'hE9};
            default: return b inside {8'h0D, 8'hA3, 8'hA4, 8'hA5, 8'hAB, 8'hAC, 8'hAD,
                                      8'hAE, 8'hAF};
        endcase
    endfunction

    // p is the last opcode byte position; returns position of the last byte consumed
    function automatic int modrm_walk(input logic [127:0] w, input int p, input bit asz,
                                      inout bit past);
        logic [7:0] m;
        logic [7:0] sb;
        bit sib;
        sib = 1'b0;
        p++;
        m = win_byte(w, p, past);
        if (!asz || m >= 8'h40) begin
            if (m < 8'hC0 && m[2:0] == 3'd4 && !asz) begin
                sib = 1'b1;
                p++;
            end
            if (m >= 8'h40 && m <= 8'h7F)
                p += 1;
            else if ((m <= 8'h3F && m[2:0] == 3'd5) || (m >= 8'h80 && m <= 8'hBF))
                p += asz ? 2 : 4;
            else if (sib) begin
                sb = win_byte(w, p, past);
                if (sb[2:0] == 3'd5)
                    p += m[6] ? 1 : 4;
            end
        end else if (m == 8'h26) begin
            // 16-bit addressing with a direct disp16
            p += 2;
        end
        return p;
    endfunction

    function automatic t_len_result predict_length(input logic [127:0] w);
        int p, offset, len, i;
        bit osz, asz, rexw, past;
        logic [7:0] b;
        logic [3:0] r, c;
        t_len_result res;
        p = 0; offset = 0; osz = 0; asz = 0; rexw = 0; past = 0;
        // legacy prefixes are taken only at positions below the limit, rex bytes at any
        // the scan always stops by position 16, where zero bytes read in
        for (i = 0; i <= 16; i++, p++) begin
            b = win_byte(w, p, past);
            if (!((i < PrefixLimit && in_list(b, 0)) || b[7:4] == 4'h4)) break;
            if (b == 8'h66) osz = 1;
            else if (b == 8'h67) asz = 1;
            else if (b[7:4] == 4'h4 && b[3]) rexw = 1;
        end
        b = win_byte(w, p, past);
        if (b == 8'h0F) begin
            p++;
            b = win_byte(w, p, past);
            if (b == 8'h38 || b == 8'h3A) begin
                if (b == 8'h3A) offset++;
                p++;
                p = modrm_walk(w, p, asz, past);
            end else begin
                r = b[7:4];
                c = b[3:0];
                if (r == 4'h8)
                    offset += 4;
                else if ((r == 4'h7 && c < 4) || b == 8'hA4 || b == 8'hC2 ||
                         (b > 8'hC3 && b <= 8'hC6) || b == 8'hBA || b == 8'hAC)
                    offset++;
                if (in_list(b, 4) || (r != 3 && r > 0 && r < 7) || b >= 8'hD0 ||
                    (r == 7 && c != 7) || r == 9 || r == 4'hB || (r == 4'hC && c < 8) ||
                    (r == 0 && c < 4))
                    p = modrm_walk(w, p, asz, past);
            end
        end else begin
            r = b[7:4];
            c = b[3:0];
            if ((r == 4'hE && c < 8) || (r == 4'hB && c < 8) || r == 7 ||
                (r < 4 && (c == 4 || c == 4'hC)) ||
                (b == 8'hF6 && (win_byte(w, p + 1, past) & 8'h30) == 0) || in_list(b, 2))
                offset++;
            else if (b == 8'hC2 || b == 8'hCA)
                offset += 2;
            else if (b == 8'hC8)
                offset += 3;
            else if ((r < 4 && (c == 5 || c == 4'hD)) || (r == 4'hB && c >= 8) ||
                     (b == 8'hF7 && (win_byte(w, p + 1, past) & 8'h30) == 0) ||
                     in_list(b, 3)) begin
                if (b >= 8'hB8 && b <= 8'hBF) offset += rexw ? 8 : 4;
                else if (b == 8'hC7 || b == 8'h69) offset += 4;
                else offset += osz ? 2 : 4;
            end else if (r == 4'hA && c < 4)
                offset += rexw ? 8 : (asz ? 2 : 4);
            else if (b == 8'hEA || b == 8'h9A)
                offset += osz ? 4 : 6;
            if (in_list(b, 1) || (r < 4 && (c < 4 || (c >= 8 && c < 4'hC))) || r == 8 ||
                (r == 4'hD && c >= 8))
                p = modrm_walk(w, p, asz, past);
        end
        len = p + 1 + offset;
        if (len > 16) begin
            len = 16;
            past = 1;
        end
        res.len = len[4:0];
        res.ovf = past;
        return res;
    endfunction

    // --------------------------------------------------------------------
    // stimulus builders
    // --------------------------------------------------------------------
    function automatic logic [127:0] rand_window();
        return {$urandom, $urandom, $urandom, $urandom};
    endfunction

    // a window shaped like real code: prefixes, rex, opcode map, random bytes after
    function automatic logic [127:0] shaped_window();
        logic [127:0] w;
        logic [7:0] pfx[11];
        int k, n;
        pfx = '{8'hF0, 8'hF2, 8'hF3, 8'h2E, 8'h36, 8'h3E, 8'h26, 8'h64, 8'h65, 8'h66, 8'h67};
        w = rand_window();
        k = 0;
        // mostly few prefixes, sometimes a long run up to and past the limit
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 16) : $urandom_range(0, 3);
        repeat (n) begin
            if (k < 16) w[8*k +: 8] = pfx[$urandom_range(0, 10)];
            k++;
        end
        if (k < 16 && $urandom_range(0, 2) == 0) begin
            w[8*k +: 8] = 8'h40 | 8'($urandom_range(0, 15));
            k++;
        end
        if (k < 16) begin
            case ($urandom_range(0, 5))
                0, 1: ;
                2: begin
                    w[8*k +: 8] = 8'h0F;
                    if (k < 15 && $urandom_range(0, 1) == 0)
                        w[8*(k+1) +: 8] = $urandom_range(0, 1) ? 8'h38 : 8'h3A;
                end
                3: w[8*k +: 8] = 8'h0F;
                4: w[8*k +: 8] = $urandom_range(0, 1) ? 8'hF6 : 8'hF7;
                default: w[8*k +: 8] = 8'hB8 | 8'($urandom_range(0, 7));
            endcase
        end
        return w;
    endfunction

    function automatic logic [127:0] bytes_to_window(input logic [7:0] b[$]);
        logic [127:0] w;
        w = '0;
        foreach (b[i]) if (i < 16) w[8*i +: 8] = b[i];
        return w;
    endfunction

    // --------------------------------------------------------------------
    // driver
    // --------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            src_idle <= 0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                length_queue.push_back(predict_length({in_ch.code_bytes_high,
                                                       in_ch.code_bytes_low}));
                void'(window_queue.pop_front());
            end
            if (src_idle > 0) begin
                src_idle <= src_idle - 1;
                in_ch.valid <= 1'b0;
            end else if (!quiet_phase && $urandom_range(0, 15) == 0
                         && !(in_ch.valid && !in_ch.ready)) begin
                src_idle <= $urandom_range(0, 16);
                in_ch.valid <= 1'b0;
            end else if (hold_sender && !(in_ch.valid && !in_ch.ready)) begin
                in_ch.valid <= 1'b0;
            end else begin
                // head of queue after any pop this cycle
                if (window_queue.size() > 0) begin
                    in_ch.valid <= 1'b1;
                    {in_ch.code_bytes_high, in_ch.code_bytes_low} <= window_queue[0];
                end else
                    in_ch.valid <= 1'b0;
            end
        end
    end

    // --------------------------------------------------------------------
    // monitor and output stall
    // --------------------------------------------------------------------
    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %0s: got %0d expected %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    always @(posedge i_clk) begin
        t_len_result want;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            snk_idle <= 0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                result_count++;
                if (out_ch.window_overflow) overflow_count++;
                if (length_queue.size() == 0)
                    report_mismatch("unexpected beat", 1, 0);
                else begin
                    want = length_queue.pop_front();
                    if (out_ch.instr_length !== want.len)
                        report_mismatch("instr_length", out_ch.instr_length, want.len);
                    if (out_ch.window_overflow !== want.ovf)
                        report_mismatch("window_overflow", out_ch.window_overflow, want.ovf);
                end
            end
            if (snk_idle > 0) begin
                snk_idle <= snk_idle - 1;
                out_ch.ready <= 1'b0;
            end else if (!quiet_phase && $urandom_range(0, 15) == 0) begin
                snk_idle <= $urandom_range(0, 16);
                out_ch.ready <= 1'b0;
            end else
                out_ch.ready <= 1'b1;
        end
    end

    // watchdog: cycles with no beat on either side
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else if (i_rst_n) begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IdleLimit) begin
                $display("watchdog expired, %0d windows and %0d lengths pending",
                         window_queue.size(), length_queue.size());
                $display("x86_64_instruction_length_decoder regression: fail");
                $finish;
            end
        end
    end

    // --------------------------------------------------------------------
    // sequence
    // --------------------------------------------------------------------
    initial begin
        logic [7:0] bl[$];
        int i;
        in_ch.valid = 1'b0;
        in_ch.code_bytes_low = '0;
        in_ch.code_bytes_high = '0;
        out_ch.ready = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: field extremes, prefix limit, rex runs, the odd cases
        window_queue.push_back('0);
        window_queue.push_back({128{1'b1}});
        window_queue.push_back({16{8'h66}});                       // prefix limit hit
        window_queue.push_back({16{8'h48}});                       // rex run to the end
        bl = '{8'h66, 8'h66, 8'h66, 8'h66, 8'h66, 8'h66, 8'h66, 8'h66, 8'h66, 8'h66,
               8'h66, 8'h66, 8'h66, 8'h66, 8'h67, 8'h90};
        window_queue.push_back(bytes_to_window(bl));               // 15th prefix as opcode
        bl = '{8'hF6, 8'h00, 8'h11};
        window_queue.push_back(bytes_to_window(bl));               // f6 with immediate
        bl = '{8'hF6, 8'h10};
        window_queue.push_back(bytes_to_window(bl));               // f6 without immediate
        bl = '{8'h66, 8'hF7, 8'h00};
        window_queue.push_back(bytes_to_window(bl));
        bl = '{8'hF7, 8'h30};
        window_queue.push_back(bytes_to_window(bl));
        bl = '{8'h67, 8'h8B, 8'h26};
        window_queue.push_back(bytes_to_window(bl));               // 16-bit disp case
        bl = '{8'h67, 8'h8B, 8'h04};
        window_queue.push_back(bytes_to_window(bl));               // no sib with 67
        bl = '{8'h8B, 8'h04, 8'h25};
        window_queue.push_back(bytes_to_window(bl));               // sib base 5
        bl = '{8'h8B, 8'h44, 8'h25};
        window_queue.push_back(bytes_to_window(bl));
        bl = '{8'h48, 8'hB8};
        window_queue.push_back(bytes_to_window(bl));               // movabs
        bl = '{8'h48, 8'hA1};
        window_queue.push_back(bytes_to_window(bl));
        bl = '{8'h67, 8'hA1};
        window_queue.push_back(bytes_to_window(bl));
        bl = '{8'h66, 8'hEA};
        window_queue.push_back(bytes_to_window(bl));
        bl = '{8'h9A};
        window_queue.push_back(bytes_to_window(bl));
        bl = '{8'hC8};
        window_queue.push_back(bytes_to_window(bl));
        bl = '{8'hC2};
        window_queue.push_back(bytes_to_window(bl));
        bl = '{8'h0F, 8'h3A, 8'h0F, 8'h84};
        window_queue.push_back(bytes_to_window(bl));
        bl = '{8'h0F, 8'h38, 8'h00, 8'h05};
        window_queue.push_back(bytes_to_window(bl));
        bl = '{8'h0F, 8'h84};
        window_queue.push_back(bytes_to_window(bl));
        bl = '{8'h0F, 8'hBA, 8'hE0};
        window_queue.push_back(bytes_to_window(bl));

        // hold the sender until the pipe drains once
        wait (window_queue.size() == 0);
        hold_sender = 1'b1;
        wait (length_queue.size() == 0);
        @(posedge i_clk);
        hold_sender = 1'b0;

        // random: mostly code-shaped windows, some pure noise
        for (i = 0; i < RandomItems; i++) begin
            if (i == RandomItems - 200) quiet_phase = 1'b1;
            window_queue.push_back(($urandom_range(0, 4) == 0) ? rand_window()
                                                                : shaped_window());
            if (window_queue.size() > 8) wait (window_queue.size() <= 8);
        end
        wait (window_queue.size() == 0);
        wait (length_queue.size() == 0);
        repeat (10) @(posedge i_clk);

        $display("checked %0d decoded lengths, %0d of them past the window",
                 result_count, overflow_count);
        if (error_count == 0 && length_queue.size() == 0)
            $display("x86_64_instruction_length_decoder regression: pass");
        else
            $display("x86_64_instruction_length_decoder regression: fail");
        $finish;
    end

endmodule

### x86_64_instruction_length_decoder.f
+incdir+design
design/xld_pkg.sv
design/xld_if.sv
design/xld_prefix.sv
design/xld_opcode.sv
design/xld_modrm.sv
design/x86_64_instruction_length_decoder.sv
sim/tb_x86_64_instruction_length_decoder.sv
